// ===== rtl/core/ipv4_l4_header_parser_defines.svh =====
// Assertion macros for the checker file of the header parser.
`ifndef IPV4_L4_HEADER_PARSER_DEFINES_SVH
`define IPV4_L4_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define IPLHP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("header parser check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define IPLHP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("header parser check failed");

`endif

// ===== rtl/core/iplhp_pkg.sv =====
// Types, constants and codes shared by the IPv4/L4 header parser files.
package iplhp_pkg;

  // Bytes past this count are ignored; the frame is judged as if cut here.
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int OFF_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Fixed byte positions within the frame.
  localparam int POS_ETYPE_HI  = 12;
  localparam int POS_ETYPE_LO  = 13;
  localparam int POS_IHL       = 14;
  localparam int POS_TLEN_HI   = 16;
  localparam int POS_TLEN_LO   = 17;
  localparam int POS_TTL       = 22;
  localparam int POS_PROTO     = 23;
  localparam int POS_SRC_FIRST = 26;
  localparam int POS_SRC_LAST  = 29;
  localparam int POS_DST_FIRST = 30;
  localparam int POS_DST_LAST  = 33;

  // Positions relative to the start of the transport header.
  localparam int L4_PORTS_END = 4;
  localparam int L4_SEQ_END   = 8;
  localparam int L4_TCP_DOFF  = 12;
  localparam int L4_TCP_FLAGS = 13;

  localparam int ETH_HDR_BYTES     = 14;
  localparam int IP_MIN_HDR_BYTES  = 20;
  localparam int IP_MIN_HDR_WORDS  = 5;
  localparam int TCP_MIN_HDR_WORDS = 5;
  localparam int TCP_MIN_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES     = 8;
  localparam int PREFIX_BYTES      = 7;
  localparam int DNS_MIN_PAYLOAD   = 12;
  localparam int TLS_MIN_PAYLOAD   = 5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] PORT_DNS       = 16'd53;
  localparam logic [7:0]  TLS_HANDSHAKE  = 8'h16;
  localparam logic [7:0]  TLS_VER_MAJOR  = 8'h03;

  typedef enum logic [1:0] {
    APP_UNKNOWN = 2'd0,
    APP_HTTP    = 2'd1,
    APP_DNS     = 2'd2,
    APP_TLS     = 2'd3
  } app_class_e;

  typedef enum logic [2:0] {
    METH_NONE   = 3'd0,
    METH_GET    = 3'd1,
    METH_POST   = 3'd2,
    METH_PUT    = 3'd3,
    METH_DELETE = 3'd4,
    METH_HEAD   = 3'd5
  } http_method_e;

  typedef logic [OFF_W-1:0] offset_t;

  // Everything the parser keeps about the frame in flight.
  typedef struct packed {
    offset_t     byte_offset;
    logic [15:0] ethertype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [7:0]  ttl;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] port_pair;
    logic [3:0]  flags;
    logic [31:0] seq;
    logic [3:0]  tcp_words;
    logic [55:0] prefix;
    offset_t     payload_count;
  } parse_state_t;

  typedef struct packed {
    logic         valid_res;
    logic [31:0]  src_addr;
    logic [31:0]  dst_addr;
    logic [7:0]   ip_proto;
    logic [15:0]  ip_total_len;
    logic [7:0]   ip_ttl;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [3:0]   tcp_flag_bits;
    logic [31:0]  tcp_seq;
    app_class_e   app_class;
    http_method_e http_method;
  } result_t;

endpackage

// ===== rtl/core/iplhp_if.sv =====
// Valid/ready channel interfaces for frame bytes in and frame summaries out.
interface iplhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface iplhp_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  ip_proto;
  logic [15:0] ip_total_len;
  logic [7:0]  ip_ttl;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [3:0]  tcp_flag_bits;
  logic [31:0] tcp_seq;
  logic [1:0]  app_class;
  logic [2:0]  http_method;

  modport source (
    output valid, output valid_res, output src_addr, output dst_addr, output ip_proto,
    output ip_total_len, output ip_ttl, output src_port, output dst_port,
    output tcp_flag_bits, output tcp_seq, output app_class, output http_method,
    input ready
  );
  modport sink (
    input valid, input valid_res, input src_addr, input dst_addr, input ip_proto,
    input ip_total_len, input ip_ttl, input src_port, input dst_port,
    input tcp_flag_bits, input tcp_seq, input app_class, input http_method,
    output ready
  );
endinterface

// ===== rtl/core/iplhp_parse.sv =====
// Per-byte field capture: frame state registers and the end-of-frame snapshot.
module iplhp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           frame_byte_i,
  input  logic                 last_byte_i,
  input  logic                 snap_take_i,
  output logic                 snap_valid_o,
  output iplhp_pkg::parse_state_t snap_o
);
  import iplhp_pkg::*;

  parse_state_t s_q, s_d, snap_q;
  logic         snap_valid_q, snap_valid_d;

  offset_t    pos, rel, pay_idx;
  logic [6:0] l4_start;
  logic [5:0] pay_off;
  logic       in_range, in_l4, is_tcp, is_udp, has_pay;

  assign pos      = s_q.byte_offset;
  assign in_range = pos < OFF_W'(MAX_FRAME_BYTES);
  assign l4_start = 7'(ETH_HDR_BYTES) + {1'b0, s_q.ihl, 2'b00};
  assign rel      = pos - OFF_W'(l4_start);
  assign in_l4    = (pos > OFF_W'(POS_IHL)) && (s_q.ihl >= 4'(IP_MIN_HDR_WORDS)) &&
                    (pos >= OFF_W'(l4_start));
  assign is_tcp   = s_q.proto == PROTO_TCP;
  assign is_udp   = s_q.proto == PROTO_UDP;
  assign pay_off  = is_tcp ? {s_q.tcp_words, 2'b00} : 6'(UDP_HDR_BYTES);
  assign has_pay  = (is_tcp && rel > OFF_W'(L4_TCP_DOFF) &&
                     s_q.tcp_words >= 4'(TCP_MIN_HDR_WORDS)) || is_udp;
  assign pay_idx  = rel - OFF_W'(pay_off);

  always_comb begin
    s_d = s_q;
    if (in_range) begin
      s_d.byte_offset = pos + OFF_W'(1);
      if (pos == OFF_W'(POS_ETYPE_HI)) s_d.ethertype[15:8] = frame_byte_i;
      if (pos == OFF_W'(POS_ETYPE_LO)) s_d.ethertype[7:0]  = frame_byte_i;
      if (pos == OFF_W'(POS_IHL))      s_d.ihl             = frame_byte_i[3:0];
      if (pos == OFF_W'(POS_TLEN_HI))  s_d.total_len[15:8] = frame_byte_i;
      if (pos == OFF_W'(POS_TLEN_LO))  s_d.total_len[7:0]  = frame_byte_i;
      if (pos == OFF_W'(POS_TTL))      s_d.ttl             = frame_byte_i;
      if (pos == OFF_W'(POS_PROTO))    s_d.proto           = frame_byte_i;
      if (pos >= OFF_W'(POS_SRC_FIRST) && pos <= OFF_W'(POS_SRC_LAST)) begin
        s_d.src_addr = {s_q.src_addr[23:0], frame_byte_i};
      end
      if (pos >= OFF_W'(POS_DST_FIRST) && pos <= OFF_W'(POS_DST_LAST)) begin
        s_d.dst_addr = {s_q.dst_addr[23:0], frame_byte_i};
      end
      if (in_l4) begin
        if (rel < OFF_W'(L4_PORTS_END)) s_d.port_pair = {s_q.port_pair[23:0], frame_byte_i};
        if (is_tcp) begin
          if (rel >= OFF_W'(L4_PORTS_END) && rel < OFF_W'(L4_SEQ_END)) begin
            s_d.seq = {s_q.seq[23:0], frame_byte_i};
          end
          if (rel == OFF_W'(L4_TCP_DOFF)) s_d.tcp_words = frame_byte_i[7:4];
          if (rel == OFF_W'(L4_TCP_FLAGS)) begin
            // Repacked as SYN, ACK, FIN, RST from the low bit up.
            s_d.flags = {frame_byte_i[2], frame_byte_i[0], frame_byte_i[4], frame_byte_i[1]};
          end
        end
        if (has_pay && rel >= OFF_W'(pay_off)) begin
          for (int i = 0; i < PREFIX_BYTES; i++) begin
            if (pay_idx == OFF_W'(i)) s_d.prefix[8*i +: 8] = frame_byte_i;
          end
          s_d.payload_count = s_q.payload_count + OFF_W'(1);
        end
      end
    end
  end

  assign snap_valid_d = (take_i && last_byte_i) ? 1'b1 :
                        (snap_take_i ? 1'b0 : snap_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q          <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      if (take_i) begin
        s_q <= last_byte_i ? '0 : s_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && last_byte_i) begin
      snap_q <= s_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

// ===== rtl/core/iplhp_classify.sv =====
// Frame verdict and application class, worked out from the end-of-frame snapshot.
module iplhp_classify (
  input  iplhp_pkg::parse_state_t snap_i,
  output iplhp_pkg::result_t      res_o
);
  import iplhp_pkg::*;

  // Method prefixes with the first character in the low byte, as the prefix is stored.
  localparam logic [31:0] PAT_GET    = " TEG";
  localparam logic [39:0] PAT_POST   = " TSOP";
  localparam logic [31:0] PAT_PUT    = " TUP";
  localparam logic [55:0] PAT_DELETE = " ETELED";
  localparam logic [39:0] PAT_HEAD   = " DAEH";

  logic [6:0]   l4_start;
  offset_t      len, rem, cnt;
  logic         ip_ok, l4_ok, ok, dns_port;
  http_method_e meth;
  app_class_e   cls;

  assign len      = snap_i.byte_offset;
  assign cnt      = snap_i.payload_count;
  assign l4_start = 7'(ETH_HDR_BYTES) + {1'b0, snap_i.ihl, 2'b00};
  assign ip_ok    = (len >= OFF_W'(ETH_HDR_BYTES + IP_MIN_HDR_BYTES)) &&
                    (snap_i.ethertype == ETHERTYPE_IPV4) &&
                    (snap_i.ihl >= 4'(IP_MIN_HDR_WORDS)) &&
                    (len >= OFF_W'(l4_start));
  assign rem      = len - OFF_W'(l4_start);

  always_comb begin
    priority if (snap_i.proto == PROTO_TCP) begin
      l4_ok = (rem >= OFF_W'(TCP_MIN_HDR_BYTES)) &&
              (snap_i.tcp_words >= 4'(TCP_MIN_HDR_WORDS)) &&
              (rem >= OFF_W'({snap_i.tcp_words, 2'b00}));
    end else if (snap_i.proto == PROTO_UDP) begin
      l4_ok = rem >= OFF_W'(UDP_HDR_BYTES);
    end else begin
      l4_ok = 1'b0;
    end
  end

  assign ok       = ip_ok && l4_ok;
  assign dns_port = (snap_i.port_pair[31:16] == PORT_DNS) ||
                    (snap_i.port_pair[15:0] == PORT_DNS);

  always_comb begin
    priority if (cnt >= OFF_W'(4) && snap_i.prefix[31:0] == PAT_GET) begin
      meth = METH_GET;
    end else if (cnt >= OFF_W'(5) && snap_i.prefix[39:0] == PAT_POST) begin
      meth = METH_POST;
    end else if (cnt >= OFF_W'(4) && snap_i.prefix[31:0] == PAT_PUT) begin
      meth = METH_PUT;
    end else if (cnt >= OFF_W'(7) && snap_i.prefix[55:0] == PAT_DELETE) begin
      meth = METH_DELETE;
    end else if (cnt >= OFF_W'(5) && snap_i.prefix[39:0] == PAT_HEAD) begin
      meth = METH_HEAD;
    end else begin
      meth = METH_NONE;
    end
  end

  always_comb begin
    priority if (meth != METH_NONE) begin
      cls = APP_HTTP;
    end else if (dns_port && cnt >= OFF_W'(DNS_MIN_PAYLOAD)) begin
      cls = APP_DNS;
    end else if (cnt >= OFF_W'(TLS_MIN_PAYLOAD) && snap_i.prefix[7:0] == TLS_HANDSHAKE &&
                 snap_i.prefix[15:8] == TLS_VER_MAJOR) begin
      cls = APP_TLS;
    end else begin
      cls = APP_UNKNOWN;
    end
  end

  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.valid_res    = 1'b1;
      res_o.src_addr     = snap_i.src_addr;
      res_o.dst_addr     = snap_i.dst_addr;
      res_o.ip_proto     = snap_i.proto;
      res_o.ip_total_len = snap_i.total_len;
      res_o.ip_ttl       = snap_i.ttl;
      res_o.src_port     = snap_i.port_pair[31:16];
      res_o.dst_port     = snap_i.port_pair[15:0];
      if (snap_i.proto == PROTO_TCP) begin
        res_o.tcp_flag_bits = snap_i.flags;
        res_o.tcp_seq       = snap_i.seq;
      end
      res_o.app_class   = cls;
      res_o.http_method = meth;
    end
  end

endmodule

// ===== rtl/core/ipv4_l4_header_parser.sv =====
// Top level of the streaming Ethernet/IPv4/TCP-UDP header parser.
//
//   Channel    Dir  Transaction                 Payload
//   frame_i    in   one frame byte              frame_byte, last_byte
//   summary_o  out  one summary per frame       valid_res .. http_method
//
// One byte is taken per cycle while frame_i.ready is high. The byte updates the frame
// state registers in the cycle it is accepted; the last byte also loads a snapshot
// register, from which the summary moves into the output register once that is free.
// Reset clears the frame state and all valid flags; no clearing pass.
// frame_i.ready falls only while a finished summary waits in the snapshot and the
// output register holds an earlier summary that summary_o has not yet taken.
module ipv4_l4_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  iplhp_in_if.sink    frame_i,
  iplhp_out_if.source summary_o
);
  import iplhp_pkg::*;

  parse_state_t snap;
  result_t      res, out_res_q;
  logic         take, snap_valid, snap_take;
  logic         out_valid_q, out_valid_d;

  // The output register frees whenever it is empty or its summary is taken now.
  assign snap_take     = snap_valid && (!out_valid_q || summary_o.ready);

  // The snapshot register is the only place the input can wait on the output;
  // bytes that are not last never need it, but ready does not look at the payload.
  assign frame_i.ready = !snap_valid || snap_take;
  assign take          = frame_i.valid && frame_i.ready;

  iplhp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .frame_byte_i (frame_i.frame_byte),
    .last_byte_i  (frame_i.last_byte),
    .snap_take_i  (snap_take),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  iplhp_classify u_classify (
    .snap_i (snap),
    .res_o  (res)
  );

  assign out_valid_d = snap_take ? 1'b1 :
                       ((out_valid_q && summary_o.ready) ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Summary payload; it only changes when a new summary moves in.
  always_ff @(posedge clk_i) begin
    if (snap_take) begin
      out_res_q <= res;
    end
  end

  assign summary_o.valid         = out_valid_q;
  assign summary_o.valid_res     = out_res_q.valid_res;
  assign summary_o.src_addr      = out_res_q.src_addr;
  assign summary_o.dst_addr      = out_res_q.dst_addr;
  assign summary_o.ip_proto      = out_res_q.ip_proto;
  assign summary_o.ip_total_len  = out_res_q.ip_total_len;
  assign summary_o.ip_ttl        = out_res_q.ip_ttl;
  assign summary_o.src_port      = out_res_q.src_port;
  assign summary_o.dst_port      = out_res_q.dst_port;
  assign summary_o.tcp_flag_bits = out_res_q.tcp_flag_bits;
  assign summary_o.tcp_seq       = out_res_q.tcp_seq;
  assign summary_o.app_class     = out_res_q.app_class;
  assign summary_o.http_method   = out_res_q.http_method;

endmodule

// ===== rtl/core/iplhp_checker.sv =====
// Port-level checks on the summary channel of the header parser, with its bind.
`include "ipv4_l4_header_parser_defines.svh"

module iplhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        valid_res_i,
  input logic [31:0] src_addr_i,
  input logic [31:0] dst_addr_i,
  input logic [7:0]  ip_proto_i,
  input logic [15:0] ip_total_len_i,
  input logic [7:0]  ip_ttl_i,
  input logic [15:0] src_port_i,
  input logic [15:0] dst_port_i,
  input logic [3:0]  tcp_flag_bits_i,
  input logic [31:0] tcp_seq_i,
  input logic [1:0]  app_class_i,
  input logic [2:0]  http_method_i
);
  import iplhp_pkg::*;

  `IPLHP_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(valid_res_i) && $stable(src_addr_i) && $stable(dst_addr_i) && $stable(tcp_seq_i))
  `IPLHP_ASSERT_NOW(a_reject_zero, out_valid_i && !valid_res_i, src_addr_i == '0 && dst_addr_i == '0 && ip_proto_i == '0 && ip_total_len_i == '0 && ip_ttl_i == '0 && src_port_i == '0 && dst_port_i == '0 && tcp_flag_bits_i == '0 && tcp_seq_i == '0 && app_class_i == '0 && http_method_i == '0)
  `IPLHP_ASSERT_NOW(a_l4_proto, out_valid_i && valid_res_i, ip_proto_i == PROTO_TCP || ip_proto_i == PROTO_UDP)
  `IPLHP_ASSERT_NOW(a_udp_no_tcp, out_valid_i && ip_proto_i == PROTO_UDP, tcp_flag_bits_i == '0 && tcp_seq_i == '0)
  `IPLHP_ASSERT_NOW(a_http_method, out_valid_i, (app_class_i == APP_HTTP) == (http_method_i != METH_NONE))

endmodule

bind ipv4_l4_header_parser iplhp_checker u_iplhp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (summary_o.valid),
  .out_ready_i     (summary_o.ready),
  .valid_res_i     (summary_o.valid_res),
  .src_addr_i      (summary_o.src_addr),
  .dst_addr_i      (summary_o.dst_addr),
  .ip_proto_i      (summary_o.ip_proto),
  .ip_total_len_i  (summary_o.ip_total_len),
  .ip_ttl_i        (summary_o.ip_ttl),
  .src_port_i      (summary_o.src_port),
  .dst_port_i      (summary_o.dst_port),
  .tcp_flag_bits_i (summary_o.tcp_flag_bits),
  .tcp_seq_i       (summary_o.tcp_seq),
  .app_class_i     (summary_o.app_class),
  .http_method_i   (summary_o.http_method)
);
